// ===== src/whh_pkg.sv =====
// Shared types for the weighted heavy-hitter summary.
package whh_pkg;

    localparam int COUNT_BITS  = 32;
    localparam int WEIGHT_BITS = 16;
    localparam int IN_KEY_BITS = 32;

    typedef enum logic [2:0] {
        CMD_HOLD,
        CMD_ADD,
        CMD_APPEND,
        CMD_SUB,
        CMD_SUB_DROP,
        CMD_SHIFT,
        CMD_ROTATE
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t                 op;
        logic [COUNT_BITS-1:0]   amount;
    } cmd_t;

    // passed from slot i to slot i+1
    typedef struct packed {
        logic [COUNT_BITS-1:0]   run;
        logic                    valid;
        logic                    hole;
    } fwd_t;

    // passed from slot i+1 down to slot i
    typedef struct packed {
        logic [COUNT_BITS-1:0]   count;
        logic                    valid;
    } slot_t;

endpackage

// ===== src/whh_cell.sv =====
// One summary slot: key, count and valid bit with neighbour links.
module whh_cell #(
    parameter int KEY_BITS = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  whh_pkg::cmd_t       cmd,
    input  logic [KEY_BITS-1:0] cmd_key,
    input  whh_pkg::fwd_t       fwd_in,
    output whh_pkg::fwd_t       fwd_out,
    input  logic [KEY_BITS-1:0] up_key,
    input  whh_pkg::slot_t      up_slot,
    output logic [KEY_BITS-1:0] key_out,
    output whh_pkg::slot_t      slot_out,
    output logic                match
);

    logic [KEY_BITS-1:0]               key_reg, key_next;
    logic [whh_pkg::COUNT_BITS-1:0]    count_reg, count_next;
    logic [whh_pkg::COUNT_BITS-1:0]    run_reg, run_next;
    logic                              valid_reg, valid_next;
    logic [whh_pkg::COUNT_BITS:0]      sum;
    logic [whh_pkg::COUNT_BITS-1:0]    diff;

    assign match          = valid_reg && (key_reg == cmd_key);
    assign key_out        = key_reg;
    assign slot_out.count = count_reg;
    assign slot_out.valid = valid_reg;
    assign fwd_out.run    = run_reg;
    assign fwd_out.valid  = valid_reg;
    assign fwd_out.hole   = !valid_reg || fwd_in.hole;

    assign sum      = {1'b0, count_reg} + {1'b0, cmd.amount};
    assign diff     = count_reg - cmd.amount;
    assign run_next = (count_reg < fwd_in.run) ? count_reg : fwd_in.run;

    always_comb
    begin
        key_next   = key_reg;
        count_next = count_reg;
        valid_next = valid_reg;
        case (cmd.op)
            whh_pkg::CMD_ADD:
            begin
                if (match)
                begin
                    count_next = sum[whh_pkg::COUNT_BITS] ? '1
                                 : sum[whh_pkg::COUNT_BITS-1:0];
                end
            end
            whh_pkg::CMD_APPEND:
            begin
                if (!valid_reg && fwd_in.valid)
                begin
                    key_next   = cmd_key;
                    count_next = cmd.amount;
                    valid_next = 1'b1;
                end
            end
            whh_pkg::CMD_SUB:
            begin
                count_next = diff;
            end
            whh_pkg::CMD_SUB_DROP:
            begin
                count_next = diff;
                valid_next = valid_reg && (count_reg != cmd.amount);
            end
            whh_pkg::CMD_SHIFT:
            begin
                if (fwd_out.hole)
                begin
                    key_next   = up_key;
                    count_next = up_slot.count;
                    valid_next = up_slot.valid;
                end
            end
            whh_pkg::CMD_ROTATE:
            begin
                key_next   = up_key;
                count_next = up_slot.count;
                valid_next = up_slot.valid;
            end
            default:
            begin
                key_next = key_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        count_reg <= count_next;
        run_reg   <= run_next;
    end

endmodule

// ===== src/weighted_heavy_hitter_summary.sv =====
// Weighted heavy-hitter summary: top level with slot chain and sequencer.
//
// Items arrive on the s_axis channel. tuser selects the operation: 0 folds
// the weighted key in tdata into the summary, 1 reads the whole summary out.
// An update produces no result; a read produces ENTRIES results on m_axis,
// one per slot in order, tuser set for a held slot and tlast on the final one.
// The summary is a row of ENTRIES slot cells; each cell compares, adds and
// subtracts for itself and hands key, count and a running minimum to its
// neighbours once per cycle.
// An update adds to a held key or appends to a free slot. With the row full
// and no hit, the minimum bubbles down the chain, then the smaller of the
// weight and that minimum is subtracted from every slot; when slots drop the
// row is compacted and the key appended with any remaining weight. A read
// rotates the row once per result and frees the input when the last result
// sits in the output register. A weight of zero is accepted and changes nothing.
// Reset empties the summary. When m_axis_tready is low the output register
// holds its item and the rotation waits; the input waits in the meantime.
module weighted_heavy_hitter_summary #(
    parameter int ENTRIES  = 4,
    parameter int KEY_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // item_key[31:0], item_weight[47:32]
    input  logic        s_axis_tuser,   // opcode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // entry_key[31:0], entry_count[63:32]
    output logic        m_axis_tuser,   // entry_valid
    output logic        m_axis_tlast    // last_slot
);

    localparam int CW = $clog2(ENTRIES + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MATCH,
        S_MIN,
        S_REDUCE,
        S_COMPACT,
        S_READ
    } state_t;

    state_t                                state_reg;
    logic [CW-1:0]                         cnt_reg;
    logic [KEY_BITS-1:0]                   key_reg;
    logic [whh_pkg::WEIGHT_BITS-1:0]       weight_reg;
    logic [whh_pkg::WEIGHT_BITS-1:0]       rem_reg;
    logic                                  out_valid_reg;
    logic [whh_pkg::COUNT_BITS-1:0]        out_key_reg;
    logic [whh_pkg::COUNT_BITS-1:0]        out_count_reg;
    logic                                  out_entry_valid_reg;
    logic                                  out_last_reg;

    whh_pkg::cmd_t                         cmd;
    whh_pkg::fwd_t                         fwd [ENTRIES+1];
    whh_pkg::slot_t                        slot_vec [ENTRIES+1];
    logic [KEY_BITS-1:0]                   key_vec [ENTRIES+1];
    logic [ENTRIES-1:0]                    match_vec;
    logic [ENTRIES-1:0]                    valid_vec;

    logic [63:0]                           in_key_wide;
    logic [63:0]                           head_key_wide;
    logic [KEY_BITS-1:0]                   in_key;
    logic [whh_pkg::COUNT_BITS-1:0]        weight_ext;
    logic [whh_pkg::COUNT_BITS-1:0]        least;
    logic                                  any_match;
    logic                                  full;
    logic                                  contiguous;
    logic                                  out_free;
    logic                                  in_accept;

    assign in_key_wide   = 64'(s_axis_tdata[31:0]);
    assign in_key        = in_key_wide[KEY_BITS-1:0];
    assign head_key_wide = 64'(key_vec[0]);
    assign weight_ext    = whh_pkg::COUNT_BITS'(weight_reg);
    assign least         = fwd[ENTRIES].run;
    assign any_match     = |match_vec;
    assign full          = valid_vec[ENTRIES-1];
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_count_reg, out_key_reg};
    assign m_axis_tuser  = out_entry_valid_reg;
    assign m_axis_tlast  = out_last_reg;

    always_comb
    begin
        contiguous = 1'b1;
        for (int i = 0; i < ENTRIES - 1; i++)
        begin
            if (!valid_vec[i] && valid_vec[i+1])
            begin
                contiguous = 1'b0;
            end
        end
    end

    // chain ends: head of the row and the wrap for rotation
    assign fwd[0].run     = '1;
    assign fwd[0].valid   = 1'b1;
    assign fwd[0].hole    = 1'b0;
    assign key_vec[ENTRIES]        = key_vec[0];
    assign slot_vec[ENTRIES].count = slot_vec[0].count;
    assign slot_vec[ENTRIES].valid = (cmd.op == whh_pkg::CMD_ROTATE) && slot_vec[0].valid;

    for (genvar g = 0; g < ENTRIES; g++)
    begin : g_cell
        whh_cell #(
            .KEY_BITS (KEY_BITS)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cmd      (cmd),
            .cmd_key  (key_reg),
            .fwd_in   (fwd[g]),
            .fwd_out  (fwd[g+1]),
            .up_key   (key_vec[g+1]),
            .up_slot  (slot_vec[g+1]),
            .key_out  (key_vec[g]),
            .slot_out (slot_vec[g]),
            .match    (match_vec[g])
        );
        assign valid_vec[g] = slot_vec[g].valid;
    end

    always_comb
    begin
        cmd.op     = whh_pkg::CMD_HOLD;
        cmd.amount = weight_ext;
        case (state_reg)
            S_MATCH:
            begin
                if (any_match)
                begin
                    cmd.op = whh_pkg::CMD_ADD;
                end
                else if (!full)
                begin
                    cmd.op = whh_pkg::CMD_APPEND;
                end
            end
            S_REDUCE:
            begin
                if (least > weight_ext)
                begin
                    cmd.op = whh_pkg::CMD_SUB;
                end
                else
                begin
                    cmd.op     = whh_pkg::CMD_SUB_DROP;
                    cmd.amount = least;
                end
            end
            S_COMPACT:
            begin
                cmd.amount = whh_pkg::COUNT_BITS'(rem_reg);
                if (!contiguous)
                begin
                    cmd.op = whh_pkg::CMD_SHIFT;
                end
                else if (rem_reg != '0)
                begin
                    cmd.op = whh_pkg::CMD_APPEND;
                end
            end
            S_READ:
            begin
                if (out_free)
                begin
                    cmd.op = whh_pkg::CMD_ROTATE;
                end
            end
            default:
            begin
                cmd.op = whh_pkg::CMD_HOLD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= S_IDLE;
            cnt_reg             <= '0;
            out_valid_reg       <= 1'b0;
            out_key_reg         <= '0;
            out_count_reg       <= '0;
            out_entry_valid_reg <= 1'b0;
            out_last_reg        <= 1'b0;
        end
        else
        begin
            if (out_free)
            begin
                out_valid_reg <= (state_reg == S_READ);
            end
            if (state_reg == S_READ && out_free)
            begin
                out_key_reg         <= slot_vec[0].valid ? head_key_wide[31:0] : '0;
                out_count_reg       <= slot_vec[0].valid ? slot_vec[0].count : '0;
                out_entry_valid_reg <= slot_vec[0].valid;
                out_last_reg        <= (cnt_reg == CW'(ENTRIES - 1));
            end
            case (state_reg)
                S_IDLE:
                begin
                    cnt_reg <= '0;
                    if (in_accept)
                    begin
                        if (s_axis_tuser)
                        begin
                            state_reg <= S_READ;
                        end
                        else if (s_axis_tdata[47:32] != '0)
                        begin
                            state_reg <= S_MATCH;
                        end
                    end
                end
                S_MATCH:
                begin
                    state_reg <= (any_match || !full) ? S_IDLE : S_MIN;
                end
                S_MIN:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CW'(ENTRIES - 1))
                    begin
                        state_reg <= S_REDUCE;
                    end
                end
                S_REDUCE:
                begin
                    state_reg <= (least > weight_ext) ? S_IDLE : S_COMPACT;
                end
                S_COMPACT:
                begin
                    if (contiguous)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_READ:
                begin
                    if (out_free)
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                        if (cnt_reg == CW'(ENTRIES - 1))
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            key_reg    <= in_key;
            weight_reg <= s_axis_tdata[47:32];
        end
        if (state_reg == S_REDUCE)
        begin
            rem_reg <= weight_reg - least[whh_pkg::WEIGHT_BITS-1:0];
        end
    end

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for the weighted heavy-hitter summary block.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          ENTRIES        = 4;
    localparam bit          OP_UPDATE      = 1'b0;
    localparam bit          OP_READ        = 1'b1;
    localparam logic [31:0] COUNT_MAX      = 32'hFFFF_FFFF;
    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          HOLD_OFF_LEN   = 400;

    typedef struct packed {
        logic [31:0] key;
        logic [31:0] count;
        logic        valid;
        logic        last;
    } slot_result_t;

    // Tracks the summary contents and the slot entries each read-out must return.
    class summary_scoreboard;
        logic [31:0]  held_key[ENTRIES];
        logic [31:0]  held_count[ENTRIES];
        int unsigned  held_used;
        slot_result_t readout_q[$];
        int unsigned  mismatches;
        int unsigned  updates_seen;
        int unsigned  reads_seen;
        int unsigned  entries_checked;

        function new();
            for (int i = 0; i < ENTRIES; i++)
            begin
                held_key[i]   = '0;
                held_count[i] = '0;
            end
            held_used       = 0;
            mismatches      = 0;
            updates_seen    = 0;
            reads_seen      = 0;
            entries_checked = 0;
        endfunction

        function void fold_weighted(logic [31:0] key, logic [31:0] w);
            logic [31:0] least;
            int          kept;
            least = COUNT_MAX;
            if (w == 0)
                return;
            for (int i = 0; i < held_used; i++)
            begin
                if (held_key[i] == key)
                begin
                    held_count[i] = (COUNT_MAX - held_count[i] < w) ? COUNT_MAX
                                                                    : held_count[i] + w;
                    return;
                end
                if (held_count[i] < least)
                    least = held_count[i];
            end
            if (held_used < ENTRIES)
            begin
                held_key[held_used]   = key;
                held_count[held_used] = w;
                held_used++;
                return;
            end
            if (least > w)
            begin
                for (int i = 0; i < held_used; i++)
                    held_count[i] = held_count[i] - w;
                return;
            end
            // minimum holders drop out, survivors close up in order
            kept = 0;
            for (int i = 0; i < held_used; i++)
            begin
                if (held_count[i] != least)
                begin
                    held_key[kept]   = held_key[i];
                    held_count[kept] = held_count[i] - least;
                    kept++;
                end
            end
            for (int i = kept; i < ENTRIES; i++)
            begin
                held_key[i]   = '0;
                held_count[i] = '0;
            end
            held_used = kept;
            if (w != least && held_used < ENTRIES)
            begin
                held_key[held_used]   = key;
                held_count[held_used] = w - least;
                held_used++;
            end
        endfunction

        function void note_item(bit op, logic [31:0] key, logic [15:0] weight);
            slot_result_t slot;
            if (op == OP_UPDATE)
            begin
                updates_seen++;
                fold_weighted(key, {16'd0, weight});
                return;
            end
            reads_seen++;
            for (int i = 0; i < ENTRIES; i++)
            begin
                slot.valid = (i < held_used);
                slot.key   = slot.valid ? held_key[i] : '0;
                slot.count = slot.valid ? held_count[i] : '0;
                slot.last  = (i == ENTRIES - 1);
                readout_q  = {readout_q, slot};
            end
        endfunction

        function void check_entry(slot_result_t got);
            slot_result_t want;
            entries_checked++;
            if (readout_q.size() == 0)
            begin
                $error("unexpected slot entry: key %h count %h", got.key, got.count);
                mismatches++;
                return;
            end
            want = readout_q.pop_front();
            if (got.key !== want.key)
            begin
                $error("entry_key mismatch: expected %h, got %h", want.key, got.key);
                mismatches++;
            end
            if (got.count !== want.count)
            begin
                $error("entry_count mismatch: expected %h, got %h", want.count, got.count);
                mismatches++;
            end
            if (got.valid !== want.valid)
            begin
                $error("entry_valid mismatch: expected %b, got %b", want.valid, got.valid);
                mismatches++;
            end
            if (got.last !== want.last)
            begin
                $error("last_slot mismatch: expected %b, got %b", want.last, got.last);
                mismatches++;
            end
        endfunction

        function int unsigned pending();
            return readout_q.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;

    summary_scoreboard board;
    bit          tx_quiet;
    bit          rx_quiet;
    bit          hold_off_req;
    int          idle_cycles;
    logic [31:0] key_pool[6];

    weighted_heavy_hitter_summary #(
        .ENTRIES  (ENTRIES),
        .KEY_BITS (32)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // output side: random back-pressure plus one long hold-off on request
    initial
    begin
        int rx_stall;
        rx_stall      = 0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_OFF_LEN) @(posedge clk);
                hold_off_req = 1'b0;
                m_axis_tready <= 1'b1;
            end
            else if (rx_stall > 0)
            begin
                m_axis_tready <= 1'b0;
                rx_stall--;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                if (!rx_quiet && $urandom_range(0, 2) == 0)
                    rx_stall = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        slot_result_t got;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                board.note_item(s_axis_tuser, s_axis_tdata[31:0], s_axis_tdata[47:32]);
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.key   = m_axis_tdata[31:0];
                got.count = m_axis_tdata[63:32];
                got.valid = m_axis_tuser;
                got.last  = m_axis_tlast;
                board.check_entry(got);
            end
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    task automatic send_item(input bit op, input logic [31:0] key, input logic [15:0] weight);
        int gap;
        gap = tx_quiet ? 0 : pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {weight, key};
        s_axis_tuser  <= op;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    task automatic send_random(input int n);
        int          r;
        logic [31:0] key;
        logic [15:0] weight;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            if ($urandom_range(0, 19) == 0)
                key_pool[$urandom_range(0, 5)] = $urandom;
            if ($urandom_range(0, 9) < 7)
                weight = 16'($urandom_range(1, 12));
            else
                weight = 16'($urandom_range(1, 65535));
            if (r < 15)
                send_item(OP_READ, $urandom, 16'($urandom));
            else if (r < 85)
                send_item(OP_UPDATE, key_pool[$urandom_range(0, 5)], weight);
            else
            begin
                key = $urandom;
                send_item(OP_UPDATE, key, weight);
            end
            // occasional stretches without gaps on either side
            if ($urandom_range(0, 39) == 0)
            begin
                tx_quiet = ~tx_quiet;
                rx_quiet = ~rx_quiet;
            end
        end
    endtask

    initial
    begin
        board         = new();
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_UPDATE;
        tx_quiet      = 1'b0;
        rx_quiet      = 1'b0;
        hold_off_req  = 1'b0;
        idle_cycles   = 0;
        for (int i = 0; i < 6; i++)
            key_pool[i] = $urandom;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty read-out, extremes, zero weight, hit, append,
        // subtract from all, drop on tie with weight, multi-drop then append
        send_item(OP_READ, 32'h0, 16'h0);
        send_item(OP_UPDATE, 32'h0000_0000, 16'd1);
        send_item(OP_UPDATE, 32'hFFFF_FFFF, 16'hFFFF);
        send_item(OP_UPDATE, 32'hA5A5_A5A5, 16'd0);
        send_item(OP_READ, 32'hFFFF_FFFF, 16'hFFFF);
        send_item(OP_UPDATE, 32'h0000_0000, 16'd3);
        send_item(OP_UPDATE, 32'h1234_5678, 16'd5);
        send_item(OP_UPDATE, 32'h8000_0000, 16'd2);
        send_item(OP_READ, 32'h0, 16'h0);
        send_item(OP_UPDATE, 32'h0F0F_0F0F, 16'd1);
        send_item(OP_READ, 32'h0, 16'h0);
        send_item(OP_UPDATE, 32'h3333_3333, 16'd1);
        send_item(OP_READ, 32'h0, 16'h0);
        send_item(OP_UPDATE, 32'h4444_4444, 16'd4);
        send_item(OP_UPDATE, 32'h5555_5555, 16'd10);
        send_item(OP_READ, 32'h0, 16'h0);
        send_item(OP_UPDATE, 32'h6666_6666, 16'd1);
        send_item(OP_UPDATE, 32'h7777_7777, 16'd1);
        send_item(OP_UPDATE, 32'h8888_8888, 16'd3);
        send_item(OP_READ, 32'h0, 16'h0);

        send_random(200);

        // long output hold-off while reads keep coming
        tx_quiet     = 1'b1;
        hold_off_req = 1'b1;
        for (int i = 0; i < 12; i++)
        begin
            if (i % 3 == 0)
                send_item(OP_READ, $urandom, 16'($urandom));
            else
                send_item(OP_UPDATE, key_pool[$urandom_range(0, 5)],
                          16'($urandom_range(1, 20)));
        end
        tx_quiet = 1'b0;

        send_random(200);

        s_axis_tvalid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);

        $display("Run covered %0d updates and %0d read-outs, %0d slot entries compared,",
                 board.updates_seen, board.reads_seen, board.entries_checked);
        $display("with random gaps on both sides and a long output hold-off.");
        if (board.mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
